// ----- hw/rtl/cfs_pkg.sv -----
// Shared types and constants for the cyclic frame schedule block.
package cfs_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PER_W     = 32;
  localparam int unsigned FRAME_W   = 63;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned DIV_CNT_W = $clog2(FRAME_W);
  localparam int unsigned GCD_K_W   = $clog2(PER_W);

  localparam logic [FRAME_W-1:0] MAJOR_MAX         = {FRAME_W{1'b1}};
  localparam logic [FRAME_W-1:0] NO_PERIODIC_MAJOR = FRAME_W'(1000000000);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SLOT_FIRST,
    OP_LOAD_P,
    OP_TAKE_FIRST,
    OP_GCD_GP,
    OP_SET_G,
    OP_DIV_LP,
    OP_GCD_PR,
    OP_DIV_LD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_LCM,
    OP_NEXT_SLOT,
    OP_FINAL,
    OP_DIV_FPM,
    OP_SET_FPM,
    OP_DIV_RATIO,
    OP_SET_RATIO,
    OP_COMMIT,
    OP_TICK,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_R_BEGIN,
    ST_R_LOAD,
    ST_R_CHECK,
    ST_R_GCD_GP_W,
    ST_R_DIV_LP,
    ST_R_DIV_LP_W,
    ST_R_GCD_PR_W,
    ST_R_DIV_LD_W,
    ST_R_MUL_HI,
    ST_R_LCM,
    ST_R_NEXT,
    ST_R_FPM,
    ST_R_FPM_W,
    ST_R_RATIO,
    ST_R_RATIO_W,
    ST_R_COMMIT,
    ST_TICK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic p_zero;
    logic any_periodic;
    logic saturated;
    logic slot_last;
    logic div_busy;
    logic gcd_busy;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

// ----- hw/rtl/cfs_ifs.sv -----
// Valid/ready channel interfaces for tick items and schedule results.
interface cfs_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cfs_out_if;
  logic                         valid;
  logic                         ready;
  logic [cfs_pkg::SLOT_W-1:0]   slot_index;
  logic                         due;
  logic                         last;
  logic [cfs_pkg::FRAME_W-1:0]  frame_index;
  logic [cfs_pkg::PER_W-1:0]    minor_period;
  logic                         overflow;

  modport source (output valid, output slot_index, output due, output last,
                  output frame_index, output minor_period, output overflow,
                  input ready);
  modport sink   (input valid, input slot_index, input due, input last,
                  input frame_index, input minor_period, input overflow,
                  output ready);
endinterface

// ----- hw/rtl/cfs_div.sv -----
// Radix-2 restoring divider: 63-bit dividend by 32-bit divisor, one bit per cycle.
module cfs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cfs_pkg::FRAME_W-1:0]  dividend,
  input  logic [cfs_pkg::PER_W-1:0]    divisor,
  output logic                         busy,
  output logic [cfs_pkg::FRAME_W-1:0]  quotient,
  output logic [cfs_pkg::PER_W-1:0]    remainder
);

  logic                          busy_r, busy_nxt;
  logic [cfs_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [cfs_pkg::FRAME_W-1:0]   quo_r, quo_nxt;
  logic [cfs_pkg::PER_W-1:0]     rem_r, rem_nxt;
  logic [cfs_pkg::PER_W-1:0]     dvs_r, dvs_nxt;
  logic [cfs_pkg::PER_W:0]       shift;
  logic [cfs_pkg::PER_W:0]       diff;
  logic                          ge;

  assign shift = {rem_r, quo_r[cfs_pkg::FRAME_W-1]};
  assign diff  = shift - {1'b0, dvs_r};
  assign ge    = (shift >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cfs_pkg::DIV_CNT_W'(cfs_pkg::FRAME_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[cfs_pkg::PER_W-1:0] : shift[cfs_pkg::PER_W-1:0];
      quo_nxt = {quo_r[cfs_pkg::FRAME_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- hw/rtl/cfs_gcd.sv -----
// Binary GCD unit on 32-bit operands, one shift or subtract step per cycle.
module cfs_gcd (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cfs_pkg::PER_W-1:0] op_a,
  input  logic [cfs_pkg::PER_W-1:0] op_b,
  output logic                      busy,
  output logic [cfs_pkg::PER_W-1:0] result
);

  logic                        busy_r, busy_nxt;
  logic [cfs_pkg::PER_W-1:0]   a_r, a_nxt;
  logic [cfs_pkg::PER_W-1:0]   b_r, b_nxt;
  logic [cfs_pkg::GCD_K_W-1:0] k_r, k_nxt;
  logic [cfs_pkg::PER_W-1:0]   res_r, res_nxt;

  always_comb begin
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    res_nxt  = res_r;
    if (start) begin
      // gcd with zero is the other operand
      if (op_a == '0) begin
        res_nxt = op_b;
      end else if (op_b == '0) begin
        res_nxt = op_a;
      end else begin
        a_nxt    = op_a;
        b_nxt    = op_b;
        k_nxt    = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r == b_r) begin
        res_nxt  = a_r << k_r;
        busy_nxt = 1'b0;
      end else if (a_r > b_r) begin
        a_nxt = (a_r - b_r) >> 1;
      end else begin
        b_nxt = (b_r - a_r) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

  assign busy   = busy_r;
  assign result = res_r;

endmodule

// ----- hw/rtl/cfs_datapath.sv -----
// Datapath: period registers, frame timing, slot countdowns and result register.
module cfs_datapath #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfs_pkg::PER_W-1:0]      cfg_wdata,
  input  cfs_pkg::cmd_t                  cmd,
  output cfs_pkg::stat_t                 stat,
  cfs_out_if.source                      out_ch
);

  localparam int unsigned PW = cfs_pkg::PER_W;
  localparam int unsigned FW = cfs_pkg::FRAME_W;
  localparam int unsigned SW = cfs_pkg::SLOT_W;

  logic [PW-1:0] per_r     [cfs_pkg::NUM_REGS];
  logic [PW-1:0] per_nxt   [cfs_pkg::NUM_REGS];
  logic [PW-1:0] ratio_r   [SLOT_COUNT];
  logic [PW-1:0] ratio_nxt [SLOT_COUNT];
  logic [PW-1:0] cnt_r     [SLOT_COUNT];
  logic [PW-1:0] cnt_nxt   [SLOT_COUNT];

  logic [SW-1:0]         s_r, s_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic [PW-1:0]         g_r, g_nxt;
  logic [FW-1:0]         l_r, l_nxt;
  logic                  any_r, any_nxt;
  logic                  sat_r, sat_nxt;
  logic [cfs_pkg::PROD_W-1:0] lo_r, lo_nxt;
  logic [FW-1:0]         hi_r, hi_nxt;
  logic [FW-1:0]         fpm_r, fpm_nxt;
  logic [FW-1:0]         frame_r, frame_nxt;
  logic [FW-1:0]         tframe_r, tframe_nxt;
  logic                  computed_r, computed_nxt;
  logic [SLOT_COUNT-1:0] mask_r, mask_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_slot_r, out_slot_nxt;
  logic          out_due_r, out_due_nxt;
  logic          out_last_r, out_last_nxt;
  logic [FW-1:0] out_frame_r, out_frame_nxt;
  logic [PW-1:0] out_minor_r, out_minor_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          div_start, div_busy;
  logic [FW-1:0] div_dvd, div_q;
  logic [PW-1:0] div_dvs, div_rem;
  logic          gcd_start, gcd_busy;
  logic [PW-1:0] gcd_a, gcd_b, gcd_res;

  logic [PW-1:0]              mul_a;
  logic [cfs_pkg::PROD_W-1:0] mul_p;
  logic [cfs_pkg::PROD_W-1:0] t_sum;
  logic [FW-1:0]              frame_inc;
  logic                       wrap;
  logic                       s_last;
  logic [PW-1:0]              per_sel;

  logic                  found;
  logic [SW-1:0]         first_idx;
  logic [SLOT_COUNT-1:0] rest;

  cfs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  cfs_gcd u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (gcd_start),
    .op_a   (gcd_a),
    .op_b   (gcd_b),
    .busy   (gcd_busy),
    .result (gcd_res)
  );

  assign per_sel   = per_r[s_r];
  assign s_last    = (s_r == SW'(SLOT_COUNT - 1));
  assign frame_inc = frame_r + 1'b1;
  assign wrap      = (frame_inc >= fpm_r);

  // split the 63x32 product into two 32x32 halves
  assign mul_a = (cmd.op == cfs_pkg::OP_MUL_HI) ? {1'b0, div_q[FW-1:PW]} : div_q[PW-1:0];
  assign mul_p = cfs_pkg::PROD_W'(mul_a) * cfs_pkg::PROD_W'(p_r);
  assign t_sum = {1'b0, hi_r} + {{PW{1'b0}}, lo_r[cfs_pkg::PROD_W-1:PW]};

  // lowest due slot of the current tick
  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
      if (mask_r[j]) begin
        found     = 1'b1;
        first_idx = SW'(j);
      end
    end
    for (int j = 0; j < SLOT_COUNT; j++) begin
      rest[j] = mask_r[j] && (SW'(j) != first_idx);
    end
  end

  always_comb begin
    per_nxt       = per_r;
    ratio_nxt     = ratio_r;
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    p_nxt         = p_r;
    g_nxt         = g_r;
    l_nxt         = l_r;
    any_nxt       = any_r;
    sat_nxt       = sat_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    fpm_nxt       = fpm_r;
    frame_nxt     = frame_r;
    tframe_nxt    = tframe_r;
    computed_nxt  = computed_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_slot_nxt  = out_slot_r;
    out_due_nxt   = out_due_r;
    out_last_nxt  = out_last_r;
    out_frame_nxt = out_frame_r;
    out_minor_nxt = out_minor_r;
    out_ovf_nxt   = out_ovf_r;
    div_start     = 1'b0;
    div_dvd       = l_r;
    div_dvs       = g_r;
    gcd_start     = 1'b0;
    gcd_a         = g_r;
    gcd_b         = p_r;

    if (cfg_we) begin
      per_nxt[cfg_index] = cfg_wdata;
    end

    unique case (cmd.op)
      cfs_pkg::OP_NONE: begin
      end
      cfs_pkg::OP_SLOT_FIRST: begin
        s_nxt   = '0;
        sat_nxt = 1'b0;
        any_nxt = 1'b0;
      end
      cfs_pkg::OP_LOAD_P: begin
        p_nxt = per_sel;
      end
      cfs_pkg::OP_TAKE_FIRST: begin
        g_nxt   = p_r;
        l_nxt   = FW'(p_r);
        any_nxt = 1'b1;
      end
      cfs_pkg::OP_GCD_GP: begin
        gcd_start = 1'b1;
      end
      cfs_pkg::OP_SET_G: begin
        g_nxt = gcd_res;
      end
      cfs_pkg::OP_DIV_LP: begin
        div_start = 1'b1;
        div_dvs   = p_r;
      end
      cfs_pkg::OP_GCD_PR: begin
        gcd_start = 1'b1;
        gcd_a     = p_r;
        gcd_b     = div_rem;
      end
      cfs_pkg::OP_DIV_LD: begin
        div_start = 1'b1;
        div_dvs   = gcd_res;
      end
      cfs_pkg::OP_MUL_LO: begin
        lo_nxt = mul_p;
      end
      cfs_pkg::OP_MUL_HI: begin
        hi_nxt = mul_p[FW-1:0];
      end
      cfs_pkg::OP_LCM: begin
        // product fits in 63 bits only if the upper sum stays below 2^31
        if (t_sum[cfs_pkg::PROD_W-1:PW-1] != '0) begin
          l_nxt   = cfs_pkg::MAJOR_MAX;
          sat_nxt = 1'b1;
        end else begin
          l_nxt = {t_sum[PW-2:0], lo_r[PW-1:0]};
        end
      end
      cfs_pkg::OP_NEXT_SLOT: begin
        s_nxt = s_r + 1'b1;
      end
      cfs_pkg::OP_FINAL: begin
        if (!any_r) begin
          g_nxt = PW'(1);
          l_nxt = cfs_pkg::NO_PERIODIC_MAJOR;
        end
      end
      cfs_pkg::OP_DIV_FPM: begin
        div_start = 1'b1;
      end
      cfs_pkg::OP_SET_FPM: begin
        fpm_nxt = (div_q == '0) ? FW'(1) : div_q;
        s_nxt   = '0;
      end
      cfs_pkg::OP_DIV_RATIO: begin
        div_start = 1'b1;
        div_dvd   = FW'(per_sel);
      end
      cfs_pkg::OP_SET_RATIO: begin
        for (int j = 0; j < SLOT_COUNT; j++) begin
          if (SW'(j) == s_r) begin
            ratio_nxt[j] = div_q[PW-1:0];
          end
        end
        if (!s_last) begin
          s_nxt = s_r + 1'b1;
        end
      end
      cfs_pkg::OP_COMMIT: begin
        for (int j = 0; j < SLOT_COUNT; j++) begin
          cnt_nxt[j] = '0;
        end
        frame_nxt    = '0;
        computed_nxt = 1'b1;
      end
      cfs_pkg::OP_TICK: begin
        for (int j = 0; j < SLOT_COUNT; j++) begin
          mask_nxt[j] = computed_r && (ratio_r[j] != '0) && (cnt_r[j] == '0);
          if (wrap) begin
            cnt_nxt[j] = '0;
          end else if (computed_r && (ratio_r[j] != '0)) begin
            cnt_nxt[j] = (cnt_r[j] == '0) ? ratio_r[j] - 1'b1 : cnt_r[j] - 1'b1;
          end
        end
        tframe_nxt = frame_r;
        frame_nxt  = wrap ? '0 : frame_inc;
      end
      cfs_pkg::OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = found ? first_idx : '0;
        out_due_nxt   = found;
        out_last_nxt  = (rest == '0);
        out_frame_nxt = tframe_r;
        out_minor_nxt = g_r;
        out_ovf_nxt   = sat_r;
        mask_nxt      = rest;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < cfs_pkg::NUM_REGS; j++) begin
        per_r[j] <= '0;
      end
      for (int j = 0; j < SLOT_COUNT; j++) begin
        cnt_r[j] <= '0;
      end
      s_r         <= '0;
      any_r       <= 1'b0;
      sat_r       <= 1'b0;
      g_r         <= PW'(1);
      fpm_r       <= FW'(1);
      frame_r     <= '0;
      computed_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      per_r       <= per_nxt;
      cnt_r       <= cnt_nxt;
      s_r         <= s_nxt;
      any_r       <= any_nxt;
      sat_r       <= sat_nxt;
      g_r         <= g_nxt;
      fpm_r       <= fpm_nxt;
      frame_r     <= frame_nxt;
      computed_r  <= computed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ratio_r     <= ratio_nxt;
    p_r         <= p_nxt;
    l_r         <= l_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    tframe_r    <= tframe_nxt;
    mask_r      <= mask_nxt;
    out_slot_r  <= out_slot_nxt;
    out_due_r   <= out_due_nxt;
    out_last_r  <= out_last_nxt;
    out_frame_r <= out_frame_nxt;
    out_minor_r <= out_minor_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign stat.p_zero       = (p_r == '0);
  assign stat.any_periodic = any_r;
  assign stat.saturated    = sat_r;
  assign stat.slot_last    = s_last;
  assign stat.div_busy     = div_busy;
  assign stat.gcd_busy     = gcd_busy;
  assign stat.out_free     = !out_valid_r || out_ch.ready;
  assign stat.emit_last    = (rest == '0);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.slot_index   = out_slot_r;
  assign out_ch.due          = out_due_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.frame_index  = out_frame_r;
  assign out_ch.minor_period = out_minor_r;
  assign out_ch.overflow     = out_ovf_r;

endmodule

// ----- hw/rtl/cfs_ctrl.sv -----
// Controller: sequences frame recompute, tick update and result beats.
module cfs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_restart,
  output logic            in_ready,
  input  cfs_pkg::stat_t  stat,
  output cfs_pkg::cmd_t   cmd
);

  cfs_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_restart ? cfs_pkg::ST_R_BEGIN : cfs_pkg::ST_TICK;
        end
      end
      cfs_pkg::ST_R_BEGIN:  state_nxt = cfs_pkg::ST_R_LOAD;
      cfs_pkg::ST_R_LOAD:   state_nxt = cfs_pkg::ST_R_CHECK;
      cfs_pkg::ST_R_CHECK: begin
        if (stat.p_zero || !stat.any_periodic) begin
          state_nxt = cfs_pkg::ST_R_NEXT;
        end else begin
          state_nxt = cfs_pkg::ST_R_GCD_GP_W;
        end
      end
      cfs_pkg::ST_R_GCD_GP_W: begin
        if (!stat.gcd_busy) begin
          state_nxt = stat.saturated ? cfs_pkg::ST_R_NEXT : cfs_pkg::ST_R_DIV_LP;
        end
      end
      cfs_pkg::ST_R_DIV_LP: state_nxt = cfs_pkg::ST_R_DIV_LP_W;
      cfs_pkg::ST_R_DIV_LP_W: begin
        if (!stat.div_busy) begin
          state_nxt = cfs_pkg::ST_R_GCD_PR_W;
        end
      end
      cfs_pkg::ST_R_GCD_PR_W: begin
        if (!stat.gcd_busy) begin
          state_nxt = cfs_pkg::ST_R_DIV_LD_W;
        end
      end
      cfs_pkg::ST_R_DIV_LD_W: begin
        if (!stat.div_busy) begin
          state_nxt = cfs_pkg::ST_R_MUL_HI;
        end
      end
      cfs_pkg::ST_R_MUL_HI: state_nxt = cfs_pkg::ST_R_LCM;
      cfs_pkg::ST_R_LCM:    state_nxt = cfs_pkg::ST_R_NEXT;
      cfs_pkg::ST_R_NEXT: begin
        state_nxt = stat.slot_last ? cfs_pkg::ST_R_FPM : cfs_pkg::ST_R_LOAD;
      end
      cfs_pkg::ST_R_FPM:    state_nxt = cfs_pkg::ST_R_FPM_W;
      cfs_pkg::ST_R_FPM_W: begin
        if (!stat.div_busy) begin
          state_nxt = cfs_pkg::ST_R_RATIO;
        end
      end
      cfs_pkg::ST_R_RATIO:  state_nxt = cfs_pkg::ST_R_RATIO_W;
      cfs_pkg::ST_R_RATIO_W: begin
        if (!stat.div_busy) begin
          state_nxt = stat.slot_last ? cfs_pkg::ST_R_COMMIT : cfs_pkg::ST_R_RATIO;
        end
      end
      cfs_pkg::ST_R_COMMIT: state_nxt = cfs_pkg::ST_TICK;
      cfs_pkg::ST_TICK:     state_nxt = cfs_pkg::ST_EMIT;
      cfs_pkg::ST_EMIT: begin
        if (stat.out_free && stat.emit_last) begin
          state_nxt = cfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = cfs_pkg::OP_NONE;
    unique case (state_r)
      cfs_pkg::ST_IDLE:      in_ready = 1'b1;
      cfs_pkg::ST_R_BEGIN:   cmd.op = cfs_pkg::OP_SLOT_FIRST;
      cfs_pkg::ST_R_LOAD:    cmd.op = cfs_pkg::OP_LOAD_P;
      cfs_pkg::ST_R_CHECK: begin
        if (stat.p_zero) begin
          cmd.op = cfs_pkg::OP_NONE;
        end else if (!stat.any_periodic) begin
          cmd.op = cfs_pkg::OP_TAKE_FIRST;
        end else begin
          cmd.op = cfs_pkg::OP_GCD_GP;
        end
      end
      cfs_pkg::ST_R_GCD_GP_W: begin
        if (!stat.gcd_busy) begin
          cmd.op = cfs_pkg::OP_SET_G;
        end
      end
      cfs_pkg::ST_R_DIV_LP:  cmd.op = cfs_pkg::OP_DIV_LP;
      cfs_pkg::ST_R_DIV_LP_W: begin
        if (!stat.div_busy) begin
          cmd.op = cfs_pkg::OP_GCD_PR;
        end
      end
      cfs_pkg::ST_R_GCD_PR_W: begin
        if (!stat.gcd_busy) begin
          cmd.op = cfs_pkg::OP_DIV_LD;
        end
      end
      cfs_pkg::ST_R_DIV_LD_W: begin
        if (!stat.div_busy) begin
          cmd.op = cfs_pkg::OP_MUL_LO;
        end
      end
      cfs_pkg::ST_R_MUL_HI:  cmd.op = cfs_pkg::OP_MUL_HI;
      cfs_pkg::ST_R_LCM:     cmd.op = cfs_pkg::OP_LCM;
      cfs_pkg::ST_R_NEXT: begin
        cmd.op = stat.slot_last ? cfs_pkg::OP_FINAL : cfs_pkg::OP_NEXT_SLOT;
      end
      cfs_pkg::ST_R_FPM:     cmd.op = cfs_pkg::OP_DIV_FPM;
      cfs_pkg::ST_R_FPM_W: begin
        if (!stat.div_busy) begin
          cmd.op = cfs_pkg::OP_SET_FPM;
        end
      end
      cfs_pkg::ST_R_RATIO:   cmd.op = cfs_pkg::OP_DIV_RATIO;
      cfs_pkg::ST_R_RATIO_W: begin
        if (!stat.div_busy) begin
          cmd.op = cfs_pkg::OP_SET_RATIO;
        end
      end
      cfs_pkg::ST_R_COMMIT:  cmd.op = cfs_pkg::OP_COMMIT;
      cfs_pkg::ST_TICK:      cmd.op = cfs_pkg::OP_TICK;
      cfs_pkg::ST_EMIT: begin
        // hold while the output register is still occupied
        if (stat.out_free) begin
          cmd.op = cfs_pkg::OP_EMIT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/cyclic_frame_schedule.sv -----
// Cyclic executive schedule: frame timing from slot periods, due slots per tick.
// Usage:
//  - cfg_we/cfg_index/cfg_wdata write the period of slot cfg_index (0 = not
//    periodic). Periods take effect at the next tick beat with restart set.
//  - in_ch carries one tick beat per minor frame; restart=1 recomputes the
//    minor frame (GCD) and major frame (LCM, saturating) and restarts at frame 0.
//  - out_ch returns one beat per due slot in slot order, or one empty beat;
//    last marks the final beat of the tick.
// Timing: a plain tick goes through ST_TICK and ST_EMIT before its first beat is
//  registered, then gives one beat per cycle while out_ch.ready is high; the next
//  tick is accepted the cycle after its final beat enters the output register.
// A restart runs a shared 63-step divider and a binary GCD unit for each periodic
//  slot after the first, then the divider once for the frames per major frame and
//  once per slot for the slot ratios; once saturated, the LCM steps are skipped.
// Reset: all periods 0, minor 1, frame 0; until the first restart every tick
//  returns a single empty beat at frame 0.
// When out_ch.ready is low the pending beat holds in the output register and
//  the block waits; no beat is dropped.
module cyclic_frame_schedule #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfs_pkg::PER_W-1:0]      cfg_wdata,
  cfs_in_if.sink                         in_ch,
  cfs_out_if.source                      out_ch
);

  cfs_pkg::cmd_t  cmd;
  cfs_pkg::stat_t stat;
  logic           in_ready;

  cfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cfs_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_ch    (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule

// ----- sim/testbench.sv -----
// Testbench for cyclic_frame_schedule: predicts due-slot beats per tick and checks each one.
`timescale 1ns / 100ps

module testbench;

  localparam int          SLOTS       = 8;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          IDLE_PCT    = 23;
  localparam logic [63:0] MAJOR_LIMIT = {1'b0, cfs_pkg::MAJOR_MAX};
  localparam logic [63:0] IDLE_MAJOR  = {1'b0, cfs_pkg::NO_PERIODIC_MAJOR};

  typedef struct {
    logic [cfs_pkg::SLOT_W-1:0]  slot;
    logic                        due;
    logic                        last;
    logic [cfs_pkg::FRAME_W-1:0] frame;
    logic [cfs_pkg::PER_W-1:0]   minor;
    logic                        ovf;
  } sched_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                          cfg_we;
  logic [cfs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cfs_pkg::PER_W-1:0]     cfg_wdata;

  cfs_in_if  tick_ch ();
  cfs_out_if sched_ch ();

  cyclic_frame_schedule #(.SLOT_COUNT(SLOTS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (tick_ch),
    .out_ch    (sched_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the schedule state
  logic [cfs_pkg::PER_W-1:0]   period_copy [cfs_pkg::NUM_REGS];
  logic [cfs_pkg::PER_W-1:0]   ratio       [cfs_pkg::NUM_REGS];
  logic [cfs_pkg::PER_W-1:0]   countdown   [cfs_pkg::NUM_REGS];
  logic [cfs_pkg::PER_W-1:0]   minor_len;
  logic [cfs_pkg::FRAME_W-1:0] frames_major;
  logic [cfs_pkg::FRAME_W-1:0] frame_no;
  logic                        sat_flag;
  logic                        timing_valid;

  logic        pending_ticks [$];
  sched_beat_t sched_beats [$];
  int          err_count = 0;
  int unsigned cycles = 0;
  bit          tick_taken = 1'b0;
  bit          steady = 1'b0;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic add_tick(input logic restart_bit);
    pending_ticks.insert(pending_ticks.size(), restart_bit);
  endtask

  function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (b != 64'd0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  task automatic clear_shadow();
    int i;
    for (i = 0; i < cfs_pkg::NUM_REGS; i++) begin
      period_copy[i] = '0;
      ratio[i]       = '0;
      countdown[i]   = '0;
    end
    minor_len    = 1;
    frames_major = 1;
    frame_no     = '0;
    sat_flag     = 1'b0;
    timing_valid = 1'b0;
  endtask

  // Recompute minor (GCD) and major (saturating LCM) frames from the periods
  task automatic latch_frame_timing();
    logic [63:0] g, l, p, q, fpm;
    bit          any;
    int          i;
    g = '0;
    l = '0;
    any = 1'b0;
    sat_flag = 1'b0;
    for (i = 0; i < SLOTS; i++) begin
      p = {32'd0, period_copy[i]};
      if (p == 64'd0) continue;
      if (!any) begin
        g = p;
        l = p;
        any = 1'b1;
        continue;
      end
      g = euclid_gcd(g, p);
      if (!sat_flag) begin
        q = l / euclid_gcd(l, p);
        if (q > MAJOR_LIMIT / p) begin
          l = MAJOR_LIMIT;
          sat_flag = 1'b1;
        end else begin
          l = q * p;
        end
      end
    end
    if (!any) begin
      g = 64'd1;
      l = IDLE_MAJOR;
    end
    minor_len = g[31:0];
    fpm = l / g;
    if (fpm == 64'd0) fpm = 64'd1;
    frames_major = fpm[cfs_pkg::FRAME_W-1:0];
    for (i = 0; i < cfs_pkg::NUM_REGS; i++) begin
      ratio[i] = (i < SLOTS && period_copy[i] != '0) ? period_copy[i] / g[31:0] : '0;
      countdown[i] = '0;
    end
    frame_no = '0;
    timing_valid = 1'b1;
  endtask

  task automatic predict_tick(input logic restart);
    sched_beat_t                  beat;
    logic [cfs_pkg::SLOT_W-1:0]   hits [$];
    logic [cfs_pkg::FRAME_W-1:0]  frame;
    int                           i;
    if (restart) latch_frame_timing();
    frame = frame_no;
    for (i = 0; i < SLOTS; i++) begin
      if (!timing_valid || ratio[i] == '0) continue;
      if (countdown[i] == '0) begin
        hits.insert(hits.size(), 3'(i));
        countdown[i] = ratio[i] - 1;
      end else begin
        countdown[i] = countdown[i] - 1;
      end
    end
    beat.frame = frame;
    beat.minor = minor_len;
    beat.ovf   = sat_flag;
    if (hits.size() == 0) begin
      beat.slot = '0;
      beat.due  = 1'b0;
      beat.last = 1'b1;
      sched_beats.insert(sched_beats.size(), beat);
    end else begin
      foreach (hits[k]) begin
        beat.slot = hits[k];
        beat.due  = 1'b1;
        beat.last = (k == hits.size() - 1);
        sched_beats.insert(sched_beats.size(), beat);
      end
    end
    // Wrap at the end of the major frame: every slot is due again
    if ({1'b0, frame} + 64'd1 >= {1'b0, frames_major}) begin
      frame_no = '0;
      for (i = 0; i < cfs_pkg::NUM_REGS; i++) countdown[i] = '0;
    end else begin
      frame_no = frame + 1;
    end
  endtask

  task automatic check_beat();
    sched_beat_t want;
    if (sched_beats.size() == 0) begin
      flag_mismatch("beat with nothing pending, slot", sched_ch.slot_index, '0);
      return;
    end
    want = sched_beats.pop_front();
    if (sched_ch.slot_index !== want.slot)
      flag_mismatch("slot_index", sched_ch.slot_index, want.slot);
    if (sched_ch.due !== want.due)
      flag_mismatch("due", sched_ch.due, want.due);
    if (sched_ch.last !== want.last)
      flag_mismatch("last", sched_ch.last, want.last);
    if (sched_ch.frame_index !== want.frame)
      flag_mismatch("frame_index", sched_ch.frame_index, want.frame);
    if (sched_ch.minor_period !== want.minor)
      flag_mismatch("minor_period", sched_ch.minor_period, want.minor);
    if (sched_ch.overflow !== want.ovf)
      flag_mismatch("overflow", sched_ch.overflow, want.ovf);
  endtask

  // Tick driver: hold the beat until it is taken, then maybe idle
  always @(negedge clk) begin
    if (!rst_n) begin
      tick_ch.valid <= 1'b0;
    end else if (!tick_ch.valid || tick_taken) begin
      if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= pending_ticks.pop_front();
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
    tick_taken = 1'b0;
  end

  always @(negedge clk) begin
    sched_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (tick_ch.valid && tick_ch.ready) begin
        predict_tick(tick_ch.restart);
        tick_taken = 1'b1;
      end
      if (sched_ch.valid && sched_ch.ready) check_beat();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycles, sched_beats.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic write_period(input int idx, input logic [cfs_pkg::PER_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= 3'(idx);
    cfg_wdata <= val;
    period_copy[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_ticks.size() != 0 || tick_ch.valid || sched_beats.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_periods(input int mode, input bit every_slot);
    logic [cfs_pkg::PER_W-1:0] val;
    int                        base;
    int                        i;
    base = $urandom_range(4, 1);
    for (i = 0; i < cfs_pkg::NUM_REGS; i++) begin
      case (mode)
        0: val = ($urandom_range(3) == 0) ? '0 : $urandom;
        1: val = '0;
        2: val = ($urandom_range(2) == 0) ? '0 : 32'hFFFF_FFFF - $urandom_range(15);
        default: val = ($urandom_range(3) == 0) ? '0 : base * $urandom_range(6, 1);
      endcase
      if (every_slot || $urandom_range(5) != 0) write_period(i, val);
    end
  endtask

  initial begin
    int phase;
    int n;
    int k;
    int rand_items;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    tick_ch.valid   = 1'b0;
    tick_ch.restart = 1'b0;
    sched_ch.ready  = 1'b0;
    clear_shadow();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Before any restart: empty beat at frame 0
    add_tick(1'b0);
    add_tick(1'b0);
    wait_idle();

    // Restart with no periodic slot
    add_tick(1'b1);
    repeat (3) add_tick(1'b0);
    wait_idle();

    // Mixed small periods: minor 2, six frames per major, watch the wrap
    write_period(0, 2);
    write_period(1, 4);
    write_period(3, 6);
    add_tick(1'b1);
    repeat (7) add_tick(1'b0);
    wait_idle();

    // New periods stay dormant until the next restart
    write_period(1, 0);
    write_period(5, 1);
    add_tick(1'b0);
    add_tick(1'b1);
    add_tick(1'b0);
    wait_idle();

    // All slots at the largest period: eight beats per tick
    for (k = 0; k < cfs_pkg::NUM_REGS; k++) write_period(k, 32'hFFFF_FFFF);
    add_tick(1'b1);
    add_tick(1'b0);
    wait_idle();

    // Huge periods: major frame saturates
    write_period(1, 32'hFFFF_FFFE);
    write_period(2, 32'h8000_0000);
    write_period(7, 3);
    add_tick(1'b1);
    add_tick(1'b0);
    wait_idle();

    rand_items = 0;
    phase = 0;
    while (rand_items < 140) begin
      steady = (phase == 3);
      load_periods($urandom_range(9), phase == 0);
      n = $urandom_range(24, 8);
      add_tick($urandom_range(99) < 85);
      for (k = 1; k < n; k++) add_tick($urandom_range(19) == 0);
      rand_items += n;
      wait_idle();
      phase++;
    end
    steady = 1'b0;

    repeat (40) @(posedge clk);
    if (sched_beats.size() != 0)
      flag_mismatch("beats never delivered", sched_beats.size(), 0);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
